[rtl/lslf_pkg.sv]
// Shared types and constants of the least-squares line fit core.
// No dependencies; used by every module of the core.
package lslf_pkg;

  localparam int SXW  = 20;   // sum of x, unsigned, up to 16 points
  localparam int SYW  = 21;   // sum of y, signed
  localparam int SXXW = 36;   // sum of x*x, unsigned
  localparam int SXYW = 36;   // sum of x*y, signed
  localparam int NW   = 5;    // point count carried with a job
  localparam int GW   = 3;    // group number

  localparam int AW   = 68;   // multiplicand shift register and product
  localparam int BW   = 20;   // multiplier operand
  localparam int TW   = 60;   // signed numerators and partial terms
  localparam int DW   = 43;   // signed determinant
  localparam int RW   = 42;   // divider remainder
  localparam int QW   = 68;   // dividend / quotient
  localparam int CNTW = 7;

  localparam logic [GW-1:0]   GROUP_SHORT = 3'd3;
  localparam int              SHORT_ROWS  = 4;
  localparam logic [BW-1:0]   SCALE       = 20'd1000;
  localparam logic [CNTW-1:0] DIV_STEPS   = 7'd68;
  localparam int              QDEPTH      = 2;

  typedef struct packed {
    logic [GW-1:0]          group;
    logic [NW-1:0]          n;
    logic [SXW-1:0]         sx;
    logic signed [SYW-1:0]  sy;
    logic [SXXW-1:0]        sxx;
    logic signed [SXYW-1:0] sxy;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } back_state_e;

  typedef enum logic [2:0] {
    OP_N_SXX,
    OP_SX_SX,
    OP_N_SXY,
    OP_SX_SY,
    OP_SXX_SY,
    OP_SX_SXY,
    OP_SCALE_A,
    OP_SCALE_B
  } op_e;

endpackage

[rtl/lslf_front.sv]
// Front end: group register, point accumulation and job hand-off.
// Depends on lslf_pkg.
module lslf_front #(
  parameter int MaxPoints = 6
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [lslf_pkg::GW-1:0]   cfg_group_i,
  input  logic                      accept_i,
  input  logic [15:0]               peak_value_i,
  input  logic signed [15:0]        range_bias_i,
  output logic                      push_o,
  output lslf_pkg::job_t            job_o
);

  localparam int RowsMax = (MaxPoints > lslf_pkg::SHORT_ROWS) ? MaxPoints
                                                              : lslf_pkg::SHORT_ROWS;
  localparam int CW = $clog2(RowsMax + 1);

  logic [lslf_pkg::GW-1:0]          group_q;
  logic [CW-1:0]                    cnt_q, cnt_d, rows;
  logic [lslf_pkg::SXW-1:0]         sx_q, sx_d;
  logic signed [lslf_pkg::SYW-1:0]  sy_q, sy_d;
  logic [lslf_pkg::SXXW-1:0]        sxx_q, sxx_d;
  logic signed [lslf_pkg::SXYW-1:0] sxy_q, sxy_d;
  logic [31:0]                      xx;
  logic signed [32:0]               xy;
  logic                             last;

  assign xx    = peak_value_i * peak_value_i;
  assign xy    = $signed({1'b0, peak_value_i}) * range_bias_i;
  assign rows  = (group_q == lslf_pkg::GROUP_SHORT) ? CW'(lslf_pkg::SHORT_ROWS)
                                                    : CW'(MaxPoints);
  assign cnt_d = cnt_q + 1'b1;
  assign sx_d  = sx_q + lslf_pkg::SXW'(peak_value_i);
  assign sy_d  = sy_q + lslf_pkg::SYW'(range_bias_i);
  assign sxx_d = sxx_q + lslf_pkg::SXXW'(xx);
  assign sxy_d = sxy_q + lslf_pkg::SXYW'(xy);
  assign last  = (cnt_d >= rows);

  assign push_o      = accept_i && last;
  assign job_o.group = group_q;
  assign job_o.n     = lslf_pkg::NW'(cnt_d);
  assign job_o.sx    = sx_d;
  assign job_o.sy    = sy_d;
  assign job_o.sxx   = sxx_d;
  assign job_o.sxy   = sxy_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q <= 3'd1;
      cnt_q   <= '0;
      sx_q    <= '0;
      sy_q    <= '0;
      sxx_q   <= '0;
      sxy_q   <= '0;
    end else if (cfg_we_i) begin
      group_q <= cfg_group_i;
      cnt_q   <= '0;
      sx_q    <= '0;
      sy_q    <= '0;
      sxx_q   <= '0;
      sxy_q   <= '0;
    end else if (accept_i) begin
      if (last) begin
        cnt_q <= '0;
        sx_q  <= '0;
        sy_q  <= '0;
        sxx_q <= '0;
        sxy_q <= '0;
      end else begin
        cnt_q <= cnt_d;
        sx_q  <= sx_d;
        sy_q  <= sy_d;
        sxx_q <= sxx_d;
        sxy_q <= sxy_d;
      end
    end
  end

endmodule

[rtl/lslf_queue.sv]
// Two-entry job queue between the accumulating front end and the solver.
// Depends on lslf_pkg.
module lslf_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lslf_pkg::job_t job_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output lslf_pkg::job_t job_o
);

  localparam int PW = $clog2(lslf_pkg::QDEPTH);

  lslf_pkg::job_t mem_q [lslf_pkg::QDEPTH];
  logic [PW-1:0]  wr_q, rd_q;
  logic [PW:0]    cnt_q;

  assign full_o  = (cnt_q == (PW+1)'(lslf_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[rtl/lslf_back.sv]
// Solver: serial shift-add multiplier and restoring divider under one sequencer.
// Depends on lslf_pkg.
module lslf_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    job_valid_i,
  input  lslf_pkg::job_t          job_i,
  output logic                    pop_o,
  output logic                    done_o,
  output logic signed [31:0]      slope_o,
  output logic signed [31:0]      intercept_o,
  output logic [lslf_pkg::GW-1:0] group_o,
  output logic                    singular_o
);

  localparam int AW = lslf_pkg::AW;
  localparam int BW = lslf_pkg::BW;
  localparam int TW = lslf_pkg::TW;
  localparam int DW = lslf_pkg::DW;
  localparam int RW = lslf_pkg::RW;
  localparam int QW = lslf_pkg::QW;

  lslf_pkg::back_state_e state_q, state_d;
  lslf_pkg::op_e         op_q, op_d, nxt_op;
  lslf_pkg::job_t        job_q, job_d, ld_job;

  logic [AW-1:0]            a_q, a_d, acc_q, acc_d, ld_a;
  logic [BW-1:0]            b_q, b_d, ld_b;
  logic                     neg_q, neg_d, ld_neg;
  logic signed [TW-1:0]     t_q, t_d, numa_q, numa_d, numb_q, numb_d, diff;
  logic signed [DW-1:0]     det_q, det_d;
  logic [QW-1:0]            dvd_q, dvd_d, quo;
  logic [RW-1:0]            rem_q, rem_d;
  logic [RW:0]              rem_sh;
  logic                     ge;
  logic [lslf_pkg::CNTW-1:0] cnt_q, cnt_d;
  logic signed [31:0]       slope_q, slope_d, icpt_q, icpt_d, sat;
  logic                     sing_q, sing_d;
  logic signed [AW:0]       p_s;
  logic signed [lslf_pkg::SXYW-1:0] sxy_abs;
  logic signed [lslf_pkg::SYW-1:0]  sy_abs;
  logic signed [TW-1:0]     numa_abs, numb_abs;

  assign nxt_op = (state_q == lslf_pkg::ST_IDLE) ? lslf_pkg::OP_N_SXX
                                                 : lslf_pkg::op_e'(3'(op_q + 3'd1));
  assign ld_job = (state_q == lslf_pkg::ST_IDLE) ? job_i : job_q;

  assign sxy_abs  = ld_job.sxy[lslf_pkg::SXYW-1] ? -ld_job.sxy : ld_job.sxy;
  assign sy_abs   = ld_job.sy[lslf_pkg::SYW-1] ? -ld_job.sy : ld_job.sy;
  assign numa_abs = numa_q[TW-1] ? -numa_q : numa_q;
  assign numb_abs = numb_q[TW-1] ? -numb_q : numb_q;

  always_comb begin
    ld_a   = AW'(ld_job.sxx);
    ld_b   = BW'(ld_job.n);
    ld_neg = 1'b0;
    unique case (nxt_op)
      lslf_pkg::OP_N_SXX: begin
        ld_a = AW'(ld_job.sxx);
        ld_b = BW'(ld_job.n);
      end
      lslf_pkg::OP_SX_SX: begin
        ld_a = AW'(ld_job.sx);
        ld_b = ld_job.sx;
      end
      lslf_pkg::OP_N_SXY: begin
        ld_a   = AW'($unsigned(sxy_abs));
        ld_b   = BW'(ld_job.n);
        ld_neg = ld_job.sxy[lslf_pkg::SXYW-1];
      end
      lslf_pkg::OP_SX_SY: begin
        ld_a   = AW'(ld_job.sx);
        ld_b   = BW'($unsigned(sy_abs));
        ld_neg = ld_job.sy[lslf_pkg::SYW-1];
      end
      lslf_pkg::OP_SXX_SY: begin
        ld_a   = AW'(ld_job.sxx);
        ld_b   = BW'($unsigned(sy_abs));
        ld_neg = ld_job.sy[lslf_pkg::SYW-1];
      end
      lslf_pkg::OP_SX_SXY: begin
        ld_a   = AW'($unsigned(sxy_abs));
        ld_b   = ld_job.sx;
        ld_neg = ld_job.sxy[lslf_pkg::SXYW-1];
      end
      lslf_pkg::OP_SCALE_A: begin
        ld_a   = AW'($unsigned(numa_abs));
        ld_b   = lslf_pkg::SCALE;
        ld_neg = numa_q[TW-1];
      end
      lslf_pkg::OP_SCALE_B: begin
        ld_a   = AW'($unsigned(numb_abs));
        ld_b   = lslf_pkg::SCALE;
        ld_neg = numb_q[TW-1];
      end
      default: ;
    endcase
  end

  assign p_s    = neg_q ? -$signed({1'b0, acc_q}) : $signed({1'b0, acc_q});
  assign diff   = t_q - TW'(p_s);
  assign rem_sh = {rem_q, dvd_q[QW-1]};
  assign ge     = (rem_sh >= {1'b0, det_q[RW-1:0]});
  assign quo    = {dvd_q[QW-2:0], ge};

  always_comb begin
    if (neg_q) begin
      if ((|quo[QW-1:32]) || (quo[31] && (|quo[30:0]))) begin
        sat = 32'sh8000_0000;
      end else begin
        sat = -$signed(quo[31:0]);
      end
    end else if (|quo[QW-1:31]) begin
      sat = 32'sh7fff_ffff;
    end else begin
      sat = $signed(quo[31:0]);
    end
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    job_d   = job_q;
    a_d     = a_q;
    b_d     = b_q;
    neg_d   = neg_q;
    acc_d   = acc_q;
    t_d     = t_q;
    numa_d  = numa_q;
    numb_d  = numb_q;
    det_d   = det_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    slope_d = slope_q;
    icpt_d  = icpt_q;
    sing_d  = sing_q;
    pop_o   = 1'b0;
    unique case (state_q)
      lslf_pkg::ST_IDLE: begin
        if (job_valid_i) begin
          pop_o   = 1'b1;
          job_d   = job_i;
          op_d    = nxt_op;
          a_d     = ld_a;
          b_d     = ld_b;
          neg_d   = ld_neg;
          acc_d   = '0;
          state_d = lslf_pkg::ST_MUL;
        end
      end
      lslf_pkg::ST_MUL: begin
        if (b_q == '0) begin
          op_d  = nxt_op;
          a_d   = ld_a;
          b_d   = ld_b;
          neg_d = ld_neg;
          acc_d = '0;
          unique case (op_q) inside
            lslf_pkg::OP_N_SXX, lslf_pkg::OP_N_SXY, lslf_pkg::OP_SXX_SY: begin
              t_d = TW'(p_s);
            end
            lslf_pkg::OP_SX_SX: begin
              det_d = DW'(diff);
              if (diff <= 0) begin
                slope_d = '0;
                icpt_d  = '0;
                sing_d  = 1'b1;
                state_d = lslf_pkg::ST_OUT;
              end
            end
            lslf_pkg::OP_SX_SY: begin
              numa_d = diff;
            end
            lslf_pkg::OP_SX_SXY: begin
              numb_d = diff;
            end
            lslf_pkg::OP_SCALE_A, lslf_pkg::OP_SCALE_B: begin
              op_d    = op_q;
              neg_d   = neg_q;
              dvd_d   = acc_q;
              rem_d   = '0;
              cnt_d   = lslf_pkg::DIV_STEPS;
              state_d = lslf_pkg::ST_DIV;
            end
            default: ;
          endcase
        end else begin
          if (b_q[0]) begin
            acc_d = acc_q + a_q;
          end
          a_d = a_q << 1;
          b_d = b_q >> 1;
        end
      end
      lslf_pkg::ST_DIV: begin
        rem_d = ge ? RW'(rem_sh - {1'b0, det_q[RW-1:0]}) : rem_sh[RW-1:0];
        dvd_d = quo;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == lslf_pkg::CNTW'(1)) begin
          if (op_q == lslf_pkg::OP_SCALE_A) begin
            slope_d = sat;
            op_d    = nxt_op;
            a_d     = ld_a;
            b_d     = ld_b;
            neg_d   = ld_neg;
            acc_d   = '0;
            state_d = lslf_pkg::ST_MUL;
          end else begin
            icpt_d  = sat;
            sing_d  = 1'b0;
            state_d = lslf_pkg::ST_OUT;
          end
        end
      end
      lslf_pkg::ST_OUT: begin
        state_d = lslf_pkg::ST_IDLE;
      end
      default: state_d = lslf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lslf_pkg::ST_IDLE;
      op_q    <= lslf_pkg::OP_N_SXX;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q   <= job_d;
    a_q     <= a_d;
    b_q     <= b_d;
    neg_q   <= neg_d;
    acc_q   <= acc_d;
    t_q     <= t_d;
    numa_q  <= numa_d;
    numb_q  <= numb_d;
    det_q   <= det_d;
    dvd_q   <= dvd_d;
    rem_q   <= rem_d;
    slope_q <= slope_d;
    icpt_q  <= icpt_d;
    sing_q  <= sing_d;
  end

  assign done_o      = (state_q == lslf_pkg::ST_OUT);
  assign slope_o     = slope_q;
  assign intercept_o = icpt_q;
  assign group_o     = job_q.group;
  assign singular_o  = sing_q;

endmodule

[rtl/least_squares_line_fit_core.sv]
// Least-squares line fit core: top level joining front end, job queue and solver.
// Depends on lslf_pkg, lslf_front, lslf_queue, lslf_back.
//
// A point is taken when start is high and busy is low; the front end
// adds it into the count and the sums of x, y, x*x and x*y. The last point of a group
// (four for group 3, MAX_POINTS otherwise) hands a job to a two-entry queue. The solver
// works one job at a time: eight serial shift-add multiplies and two restoring divides,
// run by the one-bit-per-cycle multiplier and divider; a singular fit ends after the second
// multiply. busy is high only while two fits are waiting. Each result shows for exactly
// one cycle with done_o and cannot be held off. Writing the group register clears the
// sums; cfg_ready_o is always high.
module least_squares_line_fit_core #(
  parameter int MAX_POINTS = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_group_number_i,
  input  logic               start,
  output logic               busy,
  input  logic [15:0]        peak_value_i,
  input  logic signed [15:0] range_bias_i,
  output logic               done_o,
  output logic signed [31:0] slope_milli_o,
  output logic signed [31:0] intercept_milli_o,
  output logic [2:0]         group_echo_o,
  output logic               singular_o
);

  logic           push, pop, q_valid, q_full;
  lslf_pkg::job_t f_job, q_job;

  assign cfg_ready_o = 1'b1;
  assign busy        = q_full;

  lslf_front #(
    .MaxPoints(MAX_POINTS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_group_i (cfg_group_number_i),
    .accept_i    (start && !busy),
    .peak_value_i(peak_value_i),
    .range_bias_i(range_bias_i),
    .push_o      (push),
    .job_o       (f_job)
  );

  lslf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (f_job),
    .pop_i  (pop),
    .full_o (q_full),
    .valid_o(q_valid),
    .job_o  (q_job)
  );

  lslf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(q_valid),
    .job_i      (q_job),
    .pop_o      (pop),
    .done_o     (done_o),
    .slope_o    (slope_milli_o),
    .intercept_o(intercept_milli_o),
    .group_o    (group_echo_o),
    .singular_o (singular_o)
  );

endmodule
